FILE: rtl/i2c_bus_clear_sequencer_assert.svh
// ----------------------------------------------------------------------------
// I2C bus-clear sequencer assertion macros
// Concurrent assertion helpers for the bus-clear sequencer.
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_CLEAR_SEQUENCER_ASSERT_SVH
`define I2C_BUS_CLEAR_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IBCS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IBCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ibcs_pkg.sv
// ----------------------------------------------------------------------------
// I2C bus-clear sequencer package
// Types, register indexes and reset values shared by the sequencer.
// ----------------------------------------------------------------------------
package ibcs_pkg;

    localparam int HALF_PERIOD_W = 16;
    localparam int PULSE_W       = 6;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = HALF_PERIOD_W;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [PULSE_W-1:0]       MAX_PULSES_RESET  = 6'd18;

    localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSES  = 1'b1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SETTLE   = 3'd1,
        PH_SCL_HIGH = 3'd2,
        PH_SCL_LOW  = 3'd3,
        PH_STOP_LOW = 3'd4,
        PH_STOP_REL = 3'd5
    } phase_t;

endpackage

FILE: rtl/i2c_bus_clear_sequencer.sv
// ----------------------------------------------------------------------------
// I2C bus-clear sequencer
// Issues SCL pulses until a stuck SDA is released, then sends a STOP; at the pulse limit it ends without a STOP.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_op, s_sda_level
//   m_        out        m_valid/m_ready    m_scl_level .. m_pulses_used
//   cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata
//
// One transaction per clock cycle sustained while the output is not stalled; each passes
// through the input register, then the sequencer update into the output register.
// Synchronous active-low reset clears all valids, the sequencer state and
// loads the configuration defaults (half period 5, pulse limit 18).
// A stalled output holds the pipeline; s_ready stays high while the input
// register can drain into the output register in the same cycle.
// ----------------------------------------------------------------------------
module i2c_bus_clear_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic                                 s_sda_level,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_scl_level,
    output logic                                 m_sda_pull_low,
    output logic                                 m_busy_res,
    output logic                                 m_finished,
    output logic                                 m_recovered,
    output logic [ibcs_pkg::PULSE_W-1:0]         m_pulses_used,
    input  logic                                 cfg_wr_en,
    input  logic [ibcs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ibcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import ibcs_pkg::*;

    logic [HALF_PERIOD_W-1:0] half_period_reg;
    logic [PULSE_W-1:0]       max_pulses_reg;

    logic in_valid_reg;
    logic op_reg;
    logic sda_reg;
    logic advance;

    phase_t                   phase_reg, phase_next;
    logic [HALF_PERIOD_W-1:0] delay_count_reg, delay_count_next;
    logic [PULSE_W-1:0]       pulse_count_reg, pulse_count_next;
    logic                     result_flag_reg, result_flag_next;

    logic [HALF_PERIOD_W-1:0] hp_eff;
    logic [PULSE_W-1:0]       limit;
    logic [HALF_PERIOD_W-1:0] delay_inc;
    logic                     delay_done;
    logic                     fin;
    logic                     scl_next;
    logic                     sda_pull_next;

    logic                     out_valid_reg;
    logic                     scl_reg;
    logic                     sda_pull_reg;
    logic                     busy_reg;
    logic                     finished_reg;
    logic                     recovered_reg;
    logic [PULSE_W-1:0]       pulses_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            max_pulses_reg  <= MAX_PULSES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HALF_PERIOD: half_period_reg <= cfg_wdata;
                REG_MAX_PULSES:  max_pulses_reg  <= cfg_wdata[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            sda_reg <= s_sda_level;
        end
    end

    // sequencer
    assign hp_eff     = (half_period_reg == '0) ? HALF_PERIOD_W'(1) : half_period_reg;
    assign limit      = (max_pulses_reg == '0) ? PULSE_W'(1) : max_pulses_reg;
    assign delay_inc  = delay_count_reg + HALF_PERIOD_W'(1);
    assign delay_done = (delay_inc >= hp_eff) || (delay_inc == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            delay_count_reg <= '0;
            pulse_count_reg <= '0;
            result_flag_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            delay_count_reg <= delay_count_next;
            pulse_count_reg <= pulse_count_next;
            result_flag_reg <= result_flag_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        delay_count_next = delay_count_reg;
        pulse_count_next = pulse_count_reg;
        result_flag_next = result_flag_reg;
        fin              = 1'b0;
        if (advance) begin
            if (op_reg == OP_START) begin
                if (phase_reg == PH_IDLE) begin
                    phase_next       = PH_SETTLE;
                    delay_count_next = '0;
                    pulse_count_next = '0;
                    result_flag_next = 1'b0;
                end
            end else begin
                if (phase_reg != PH_IDLE) begin
                    delay_count_next = delay_done ? '0 : delay_inc;
                end
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_SETTLE: begin
                        if (delay_done) begin
                            if (sda_reg) begin
                                result_flag_next = 1'b1;
                                phase_next       = PH_IDLE;
                                fin              = 1'b1;
                            end else begin
                                pulse_count_next = PULSE_W'(1);
                                phase_next       = PH_SCL_HIGH;
                            end
                        end
                    end
                    PH_SCL_HIGH: begin
                        if (delay_done) begin
                            phase_next = PH_SCL_LOW;
                        end
                    end
                    PH_SCL_LOW: begin
                        if (delay_done) begin
                            if (sda_reg) begin
                                phase_next = PH_STOP_LOW;
                            end else if (pulse_count_reg >= limit) begin
                                result_flag_next = 1'b0;
                                phase_next       = PH_IDLE;
                                fin              = 1'b1;
                            end else begin
                                pulse_count_next = pulse_count_reg + PULSE_W'(1);
                                phase_next       = PH_SCL_HIGH;
                            end
                        end
                    end
                    PH_STOP_LOW: begin
                        if (delay_done) begin
                            phase_next = PH_STOP_REL;
                        end
                    end
                    PH_STOP_REL: begin
                        if (delay_done) begin
                            result_flag_next = 1'b1;
                            phase_next       = PH_IDLE;
                            fin              = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign scl_next      = !((phase_next == PH_SCL_LOW) || (phase_next == PH_STOP_LOW));
    assign sda_pull_next = (phase_next == PH_STOP_LOW);

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            scl_reg       <= scl_next;
            sda_pull_reg  <= sda_pull_next;
            busy_reg      <= (phase_next != PH_IDLE);
            finished_reg  <= fin;
            recovered_reg <= result_flag_next;
            pulses_reg    <= pulse_count_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_scl_level    = scl_reg;
    assign m_sda_pull_low = sda_pull_reg;
    assign m_busy_res     = busy_reg;
    assign m_finished     = finished_reg;
    assign m_recovered    = recovered_reg;
    assign m_pulses_used  = pulses_reg;

`include "i2c_bus_clear_sequencer_assert.svh"

    `IBCS_ASSERT_IMPLY(a_fin_not_busy, aclk, aresetn, m_valid && m_finished, !m_busy_res, "finished transaction reports busy")
    `IBCS_ASSERT_IMPLY(a_stop_scl_low, aclk, aresetn, m_valid && m_sda_pull_low, !m_scl_level, "SDA pulled low while SCL released")
    `IBCS_ASSERT_IMPLY(a_pulse_nonzero, aclk, aresetn, phase_reg == PH_SCL_HIGH || phase_reg == PH_SCL_LOW || phase_reg == PH_STOP_LOW || phase_reg == PH_STOP_REL, pulse_count_reg != '0, "pulse phase with zero pulse count")
    `IBCS_ASSERT_IMPLY(a_delay_bound, aclk, aresetn, phase_reg != PH_IDLE, delay_count_reg < hp_eff, "delay counter beyond half period")

endmodule
